[hdl/spm_pkg.sv]
// Shared types and constants of the resampling sample player.
`default_nettype none

package spm_pkg;

    typedef logic [2:0] func_t;

    localparam func_t FUNC_TICK  = 3'd0;
    localparam func_t FUNC_PLAY  = 3'd1;
    localparam func_t FUNC_STOP  = 3'd2;
    localparam func_t FUNC_SPEED = 3'd3;
    localparam func_t FUNC_QUEUE = 3'd4;
    localparam func_t FUNC_WRITE = 3'd5;

    localparam logic [7:0] SILENCE = 8'd128;

    localparam int ADDR_IN_W = 12;
    localparam int LEN_W     = 13;
    localparam int INC_W     = 16;
    // Step register holds 1.0 even at the widest fraction, hence one bit more.
    localparam int STEP_W    = 17;
    localparam int ACC_W     = 18;

    // Per-item status handed from the voice logic to the output stage.
    typedef struct packed {
        logic use_mem;
        logic playing;
    } res_t;

endpackage

`default_nettype wire

[hdl/spm_ifs.sv]
// Command and sample channel interfaces of the resampling sample player.
`default_nettype none

interface spm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [11:0] address;
    logic [12:0] length;
    logic        repeat_req;
    logic [15:0] increment;
    logic [7:0]  sample_in;

    modport source (output valid, func, address, length, repeat_req, increment, sample_in,
                    input ready);
    modport sink   (input valid, func, address, length, repeat_req, increment, sample_in,
                    output ready);
endinterface

interface spm_smp_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_out;
    logic       playing;

    modport source (output valid, sample_out, playing, input ready);
    modport sink   (input valid, sample_out, playing, output ready);
endinterface

`default_nettype wire

[hdl/spm_sample_mem.sv]
// Sample memory: one write port, one read port with registered read data.
`default_nettype none

module spm_sample_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/spm_voice.sv]
// Playback state: address, phase, remaining count, step and queued sound.
`default_nettype none

module spm_voice #(
    parameter int FRAC_BITS = 8,
    parameter int AW        = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     take,
    input  wire spm_pkg::func_t           func,
    input  wire logic [AW-1:0]            addr,
    input  wire logic [spm_pkg::LEN_W-1:0] length,
    input  wire logic                     repeat_req,
    input  wire logic [spm_pkg::INC_W-1:0] increment,
    output logic                          rd_en,
    output logic      [AW-1:0]            rd_addr,
    output spm_pkg::res_t                 res
);

    localparam int LW = spm_pkg::LEN_W;
    localparam int SW = spm_pkg::STEP_W;

    logic [AW-1:0]        cur_addr_reg, cur_addr_next;
    logic [LW-1:0]        rem_reg, rem_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [AW-1:0]        nxt_addr_reg, nxt_addr_next;
    logic [LW-1:0]        nxt_cnt_reg, nxt_cnt_next;

    logic                     active;
    logic [spm_pkg::ACC_W-1:0] acc;
    logic [LW-1:0]            whole;

    assign active = (rem_reg != '0);
    assign acc    = spm_pkg::ACC_W'(frac_reg) + spm_pkg::ACC_W'(step_reg);
    assign whole  = LW'(acc >> FRAC_BITS);

    assign rd_en   = take && (func == spm_pkg::FUNC_TICK) && active;
    assign rd_addr = cur_addr_reg;

    always_comb
    begin
        cur_addr_next = cur_addr_reg;
        rem_next      = rem_reg;
        frac_next     = frac_reg;
        step_next     = step_reg;
        nxt_addr_next = nxt_addr_reg;
        nxt_cnt_next  = nxt_cnt_reg;
        if (take)
        begin
            unique case (func)
                spm_pkg::FUNC_TICK:
                begin
                    if (active)
                    begin
                        frac_next = acc[FRAC_BITS-1:0];
                        // Running out of samples reloads the queued sound.
                        if (whole >= rem_reg)
                        begin
                            rem_next      = nxt_cnt_reg;
                            cur_addr_next = nxt_addr_reg;
                        end
                        else
                        begin
                            rem_next      = rem_reg - whole;
                            cur_addr_next = cur_addr_reg + AW'(whole);
                        end
                    end
                end
                spm_pkg::FUNC_PLAY:
                begin
                    nxt_cnt_next = repeat_req ? length : '0;
                    if (repeat_req)
                    begin
                        nxt_addr_next = addr;
                    end
                    step_next     = SW'(increment);
                    frac_next     = '0;
                    cur_addr_next = addr;
                    rem_next      = length;
                end
                spm_pkg::FUNC_STOP:
                begin
                    rem_next = '0;
                end
                spm_pkg::FUNC_SPEED:
                begin
                    step_next = SW'(increment);
                end
                spm_pkg::FUNC_QUEUE:
                begin
                    if (!(active && nxt_addr_reg == addr && nxt_cnt_reg == length))
                    begin
                        if (!active)
                        begin
                            cur_addr_next = addr;
                            rem_next      = length;
                        end
                        nxt_addr_next = addr;
                        nxt_cnt_next  = length;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res.use_mem = rd_en;
    assign res.playing = (rem_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg <= '0;
            rem_reg      <= '0;
            frac_reg     <= '0;
            step_reg     <= SW'(1) << FRAC_BITS;
            nxt_addr_reg <= '0;
            nxt_cnt_reg  <= '0;
        end
        else
        begin
            cur_addr_reg <= cur_addr_next;
            rem_reg      <= rem_next;
            frac_reg     <= frac_next;
            step_reg     <= step_next;
            nxt_addr_reg <= nxt_addr_next;
            nxt_cnt_reg  <= nxt_cnt_next;
        end
    end

endmodule

`default_nettype wire

[hdl/resampling_sample_player.sv]
// Top level of the resampling sample player: voice state, sample memory, output stage.
//
//  Channel  Modport  Transaction
//  cmd      sink     one command: tick, play, stop, speed, queue or sample write
//  smp      source   one result per command: sample byte and playing flag
//
//  One command is taken per cycle while results drain; a result passes the pending
//  stage, which spans the registered sample memory read, then the output register.
//  The voice state is updated at the accepting edge, so commands do not wait
//  on each other. A stalled result holds the read data and a second one waits
//  in the pending stage; cmd.ready drops only when both are full.
//  rst_n clears all control and voice state asynchronously; the sample
//  memory keeps no reset and holds whatever was written.
//  MEM_DEPTH must be a power of two, which the block does not check; addresses wrap at it.
`default_nettype none

module resampling_sample_player #(
    parameter int FRAC_BITS = 8,
    parameter int MEM_DEPTH = 4096
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spm_cmd_if.sink     cmd,
    spm_smp_if.source   smp
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic          take;
    logic [AW-1:0] in_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    spm_pkg::res_t res;

    logic          pend_reg, pend_next;
    spm_pkg::res_t pend_res_reg;
    logic          pend_move;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_sample_reg;
    logic          out_playing_reg;

    assign pend_move = pend_reg && (!out_valid_reg || smp.ready);
    assign cmd.ready = !pend_reg || pend_move;
    assign take      = cmd.valid && cmd.ready;
    assign in_addr   = AW'({{(32 - spm_pkg::ADDR_IN_W){1'b0}}, cmd.address});

    spm_voice #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_voice (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .func       (cmd.func),
        .addr       (in_addr),
        .length     (cmd.length),
        .repeat_req (cmd.repeat_req),
        .increment  (cmd.increment),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .res        (res)
    );

    spm_sample_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (take && cmd.func == spm_pkg::FUNC_WRITE),
        .wr_addr (in_addr),
        .wr_data (cmd.sample_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (take)
        begin
            pend_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (smp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_res_reg <= res;
        end
        if (pend_move)
        begin
            out_sample_reg  <= pend_res_reg.use_mem ? rd_data : spm_pkg::SILENCE;
            out_playing_reg <= pend_res_reg.playing;
        end
    end

    assign smp.valid      = out_valid_reg;
    assign smp.sample_out = out_sample_reg;
    assign smp.playing    = out_playing_reg;

`ifndef SYNTHESIS
    // Only a tick that finds a sound playing may use the memory read.
    a_nontick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.func != spm_pkg::FUNC_TICK |=> pend_reg && !pend_res_reg.use_mem)
        else $error("non-tick transaction marked as memory read");

    // A stop always leaves the block idle.
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.func == spm_pkg::FUNC_STOP |=> !pend_res_reg.playing)
        else $error("stop left the voice playing");

    // With both result stages full and the output stalled, no command is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_valid_reg && !smp.ready |-> !cmd.ready)
        else $error("command accepted while results are backed up");

    // A pending result that cannot move keeps its place.
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !pend_move |=> pend_reg)
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire
